>>> sv/sorted_deadline_timer_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted deadline timer queue: assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// same-cycle implication
`define SDTQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDTQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue: package
// Field widths, operation and status codes, sequencer states, store control.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam int MAX_TIMERS_DEF = 32;
    localparam int TIME_BITS_DEF  = 32;
    localparam int TICK_BURST     = 32;
    localparam int BURST_W        = $clog2(TICK_BURST + 1);

    localparam int OP_W     = 2;
    localparam int HANDLE_W = 5;
    localparam int DL_W     = 32;
    localparam int ST_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DUPLICATE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_DECIDE,
        S_RM_RD,
        S_RM_WR,
        S_RM_END,
        S_POS_START,
        S_POS_RD,
        S_POS_CHK,
        S_UP_CHK,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_EMIT,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_END
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_ctl_t;

endpackage

>>> sv/sdtq_cmd_if.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue: command channel
// Valid/ready channel carrying one queue operation per transfer.
// ----------------------------------------------------------------------------
interface sdtq_cmd_if import sdtq_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [HANDLE_W-1:0] timer_handle;
    logic [DL_W-1:0]     deadline;
    logic [DL_W-1:0]     now_time;

    modport source (
        output valid, opcode, timer_handle, deadline, now_time,
        input  ready
    );

    modport sink (
        input  valid, opcode, timer_handle, deadline, now_time,
        output ready
    );

endinterface

>>> sv/sdtq_res_if.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue: result channel
// Valid/ready channel carrying one status or expired timer per transfer.
// ----------------------------------------------------------------------------
interface sdtq_res_if import sdtq_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [ST_W-1:0]     status;
    logic                expired_valid;
    logic [HANDLE_W-1:0] expired_handle;
    logic                last;

    modport source (
        output valid, status, expired_valid, expired_handle, last,
        input  ready
    );

    modport sink (
        input  valid, status, expired_valid, expired_handle, last,
        output ready
    );

endinterface

>>> sv/sorted_deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue
// Timers held in ascending deadline order in a ring of cells, worked on by a
// sequencer around one read port, one write port and one deadline comparator.
//
//   channel  dir  payload                                        transfer
//   cmd      in   opcode, timer_handle, deadline, now_time       valid & ready
//   res      out  status, expired_valid, expired_handle, last    valid & ready
//
// Insert, adjust and delete first scan for the handle; insert then finds its
// place by deadline, shifts later timers up and writes; delete shifts later
// timers down; adjust deletes, then places the timer anew; tick pops expired
// timers from the head, at most TICK_BURST per command, the last one with last.
// Reset empties the queue at once through the fill count; no clearing pass.
// cmd is ready only between operations; a stalled res holds the sequencer.
// ----------------------------------------------------------------------------
`include "sorted_deadline_timer_queue_macros.svh"

module sorted_deadline_timer_queue import sdtq_pkg::*; #(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sdtq_cmd_if.sink    cmd,
    sdtq_res_if.source  res
);

    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int SW = CW + 1;
    localparam int DW = (TIME_BITS < DL_W) ? TIME_BITS : DL_W;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TIMERS);

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(MAX_TIMERS))
            s = s - SW'(MAX_TIMERS);
        return s[AW-1:0];
    endfunction

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    status_t              st_reg, st_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic [BURST_W-1:0]   burst_reg, burst_next;
    logic [HANDLE_W-1:0]  pend_reg, pend_next;

    logic                 res_valid_reg, res_valid_next;
    status_t              res_status_reg, res_status_next;
    logic                 res_ev_reg, res_ev_next;
    logic [HANDLE_W-1:0]  res_eh_reg, res_eh_next;
    logic                 res_last_reg, res_last_next;

    store_ctl_t           ctl;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [TIME_BITS-1:0] wr_deadline, rd_deadline, dl_in, now_in;
    logic [HANDLE_W-1:0]  wr_handle, rd_handle;
    logic [CW-1:0]        idx_inc, idx_dec;
    logic                 res_free, cmd_ready, tick_pop, dl_later;

    assign dl_in    = TIME_BITS'(cmd.deadline[DW-1:0]);
    assign now_in   = TIME_BITS'(cmd.now_time[DW-1:0]);
    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign res_free = !res_valid_reg || res.ready;
    // dl_reg holds the deadline, or the current time for a tick
    assign dl_later = (rd_deadline > dl_reg);

    sdtq_store #(
        .DEPTH     (MAX_TIMERS),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .clk         (clk),
        .ctl         (ctl),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr_deadline (wr_deadline),
        .wr_handle   (wr_handle),
        .rd_deadline (rd_deadline),
        .rd_handle   (rd_handle)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        st_next         = st_reg;
        handle_next     = handle_reg;
        dl_next         = dl_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        burst_next      = burst_reg;
        pend_next       = pend_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_status_next = res_status_reg;
        res_ev_next     = res_ev_reg;
        res_eh_next     = res_eh_reg;
        res_last_next   = res_last_reg;
        ctl             = '0;
        rd_addr         = phys(head_reg, idx_reg);
        wr_addr         = phys(head_reg, idx_reg);
        wr_deadline     = rd_deadline;
        wr_handle       = rd_handle;
        cmd_ready       = 1'b0;
        tick_pop        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd.valid)
                begin
                    op_next     = op_t'(cmd.opcode);
                    handle_next = cmd.timer_handle;
                    dl_next     = (op_t'(cmd.opcode) == OP_TICK) ? now_in : dl_in;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    burst_next  = '0;
                    if (op_t'(cmd.opcode) == OP_TICK)
                        state_next = S_TICK_RD;
                    else if (count_reg == '0)
                        state_next = S_DECIDE;
                    else
                        state_next = S_FIND_RD;
                end
            end

            S_FIND_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_FIND_CHK;
            end

            S_FIND_CHK:
            begin
                if (rd_handle == handle_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = idx_reg;
                    state_next = S_DECIDE;
                end
                else if (idx_inc == count_reg)
                    state_next = S_DECIDE;
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FIND_RD;
                end
            end

            S_DECIDE:
            begin
                st_next = ST_OK;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (found_reg)
                        begin
                            st_next    = ST_DUPLICATE;
                            state_next = S_EMIT;
                        end
                        else if (count_reg == COUNT_MAX)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_EMIT;
                        end
                        else
                            state_next = S_POS_START;
                    end
                    OP_ADJUST, OP_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            st_next    = ST_NOT_FOUND;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            idx_next = pos_reg;
                            if (pos_reg + CW'(1) == count_reg)
                                state_next = S_RM_END;
                            else
                                state_next = S_RM_RD;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end

            S_RM_RD:
            begin
                ctl.rd_en  = 1'b1;
                rd_addr    = phys(head_reg, idx_inc);
                state_next = S_RM_WR;
            end

            S_RM_WR:
            begin
                ctl.wr_en = 1'b1;
                idx_next  = idx_inc;
                if (idx_inc + CW'(1) == count_reg)
                    state_next = S_RM_END;
                else
                    state_next = S_RM_RD;
            end

            S_RM_END:
            begin
                count_next = count_reg - CW'(1);
                if (op_reg == OP_ADJUST)
                    state_next = S_POS_START;
                else
                    state_next = S_EMIT;
            end

            S_POS_START:
            begin
                idx_next = '0;
                if (count_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = S_UP_CHK;
                end
                else
                    state_next = S_POS_RD;
            end

            S_POS_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_POS_CHK;
            end

            S_POS_CHK:
            begin
                if (dl_later)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_UP_CHK;
                end
                else if (idx_inc == count_reg)
                begin
                    pos_next   = count_reg;
                    idx_next   = count_reg;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_POS_RD;
                end
            end

            S_UP_CHK:
            begin
                if (idx_reg == pos_reg)
                    state_next = S_INS_WR;
                else
                    state_next = S_UP_RD;
            end

            S_UP_RD:
            begin
                ctl.rd_en  = 1'b1;
                rd_addr    = phys(head_reg, idx_dec);
                state_next = S_UP_WR;
            end

            S_UP_WR:
            begin
                ctl.wr_en  = 1'b1;
                idx_next   = idx_dec;
                state_next = S_UP_CHK;
            end

            S_INS_WR:
            begin
                ctl.wr_en   = 1'b1;
                wr_addr     = phys(head_reg, pos_reg);
                wr_deadline = dl_reg;
                wr_handle   = handle_reg;
                count_next  = count_reg + CW'(1);
                state_next  = S_EMIT;
            end

            S_EMIT:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = st_reg;
                    res_ev_next     = 1'b0;
                    res_eh_next     = '0;
                    res_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_TICK_RD:
            begin
                if (burst_reg == BURST_W'(TICK_BURST) || count_reg == '0)
                    state_next = S_TICK_END;
                else
                begin
                    ctl.rd_en  = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_TICK_CHK;
                end
            end

            S_TICK_CHK:
            begin
                if (!dl_later)
                begin
                    if (burst_reg == '0 || res_free)
                    begin
                        // earlier pop is not the final one: send it now
                        if (burst_reg != '0)
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = ST_OK;
                            res_ev_next     = 1'b1;
                            res_eh_next     = pend_reg;
                            res_last_next   = 1'b0;
                        end
                        tick_pop   = 1'b1;
                        pend_next  = rd_handle;
                        head_next  = phys(head_reg, CW'(1));
                        count_next = count_reg - CW'(1);
                        burst_next = burst_reg + BURST_W'(1);
                        state_next = S_TICK_RD;
                    end
                end
                else
                    state_next = S_TICK_END;
            end

            S_TICK_END:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_OK;
                    res_ev_next     = (burst_reg != '0);
                    res_eh_next     = (burst_reg != '0) ? pend_reg : '0;
                    res_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        st_reg         <= st_next;
        handle_reg     <= handle_next;
        dl_reg         <= dl_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        found_reg      <= found_next;
        burst_reg      <= burst_next;
        pend_reg       <= pend_next;
        res_status_reg <= res_status_next;
        res_ev_reg     <= res_ev_next;
        res_eh_reg     <= res_eh_next;
        res_last_reg   <= res_last_next;
    end

    assign cmd.ready          = cmd_ready;
    assign res.valid          = res_valid_reg;
    assign res.status         = res_status_reg;
    assign res.expired_valid  = res_ev_reg;
    assign res.expired_handle = res_eh_reg;
    assign res.last           = res_last_reg;

    `SDTQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= COUNT_MAX, "fill count beyond capacity")
    `SDTQ_ASSERT_NXT(a_busy_after_cmd, cmd.valid && cmd.ready, !cmd.ready, "ready while busy")
    `SDTQ_ASSERT_IMP(a_expired_ok, res.valid && res.expired_valid, res.status == ST_OK, "expired with error status")
    `SDTQ_ASSERT_NXT(a_pop_count, tick_pop, count_reg == $past(count_reg) - CW'(1), "pop without count drop")
    `SDTQ_ASSERT_NXT(a_ins_count, state_reg == S_INS_WR, count_reg == $past(count_reg) + CW'(1), "insert without count rise")

endmodule

>>> sv/sdtq_store.sv
// ----------------------------------------------------------------------------
// Sorted deadline timer queue: cell store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdtq_store import sdtq_pkg::*; #(
    parameter int  DEPTH     = MAX_TIMERS_DEF,
    parameter int  TIME_BITS = TIME_BITS_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  store_ctl_t           ctl,
    input  logic [AW-1:0]        rd_addr,
    input  logic [AW-1:0]        wr_addr,
    input  logic [TIME_BITS-1:0] wr_deadline,
    input  logic [HANDLE_W-1:0]  wr_handle,
    output logic [TIME_BITS-1:0] rd_deadline,
    output logic [HANDLE_W-1:0]  rd_handle
);

    logic [TIME_BITS-1:0] mem_deadline [DEPTH];
    logic [HANDLE_W-1:0]  mem_handle   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_deadline[wr_addr] <= wr_deadline;
            mem_handle[wr_addr]   <= wr_handle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_deadline <= mem_deadline[rd_addr];
            rd_handle   <= mem_handle[rd_addr];
        end
    end

endmodule
